FILE: rtl/tftp_client_receive_defines.svh
// Assertion helpers for the TFTP receive controller.
`ifndef TFTP_CLIENT_RECEIVE_DEFINES_SVH
`define TFTP_CLIENT_RECEIVE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TFTP_RX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TFTP_RX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tftp_rx_pkg.sv
package tftp_rx_pkg;

	localparam logic [15:0] HDR_MIN_LEN = 16'd32;
	localparam logic [15:0] UDP_MIN_LEN = 16'd12;
	localparam logic [7:0]  PROTO_UDP   = 8'd17;
	localparam logic [15:0] OP_DATA     = 16'd3;
	localparam logic [15:0] OP_ERROR    = 16'd5;

	localparam logic [31:0] OWN_IP_RST      = 32'd0;
	localparam logic [31:0] SERVER_IP_RST   = 32'd0;
	localparam logic [15:0] OWN_PORT_RST    = 16'd0;
	localparam logic [3:0]  RETRY_LIMIT_RST = 4'd7;
	localparam logic [15:0] BLOCK_SIZE_RST  = 16'd512;

	typedef enum logic [1:0] {
		REQ_PACKET  = 2'd0,
		REQ_TIMEOUT = 2'd1,
		REQ_START   = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ACT_IGNORED     = 3'd0,
		ACT_DATA_ACK    = 3'd1,
		ACT_SERVER_ERR  = 3'd2,
		ACT_RESEND_REQ  = 3'd3,
		ACT_RESEND_ACK  = 3'd4,
		ACT_GIVE_UP     = 3'd5,
		ACT_FINISHED    = 3'd6,
		ACT_REQUEST     = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		CFG_OWN_IP      = 3'd0,
		CFG_SERVER_IP   = 3'd1,
		CFG_OWN_PORT    = 3'd2,
		CFG_RETRY_LIMIT = 3'd3,
		CFG_BLOCK_SIZE  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		action_t     action;
		logic [3:0]  count;
	} retry_t;

	// Timeout or out-of-order block: finish, give up, or resend.
	function automatic retry_t retry_step(input logic last, input logic [3:0] count,
		input logic [3:0] limit, input logic [15:0] blocks);
		retry_t r;
		r.count = count;
		if (last) begin
			r.action = ACT_FINISHED;
		end else if (count >= limit) begin
			r.action = ACT_GIVE_UP;
		end else begin
			r.count  = count + 4'd1;
			r.action = (blocks == 16'd0) ? ACT_RESEND_REQ : ACT_RESEND_ACK;
		end
		return r;
	endfunction

endpackage

FILE: rtl/tftp_client_receive.sv
// TFTP read-transfer receive controller. Each request (parsed packet header,
// receive timeout or session start) yields exactly one result. Requests enter
// an input register and the result is computed from it combinationally into
// the output register; one request is taken every cycle unless in_stall is
// high; session state updates as each result is registered. in_stall rises
// only when both the input register and the output register are full and the
// output is stalled. Configuration writes are always ready (cfg_ready high)
// and take effect on the next cycle; write only while the block is idle.
`include "tftp_client_receive_defines.svh"

module tftp_client_receive (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] frame_length,
	input  logic [15:0] ip_total_length,
	input  logic [7:0]  ip_protocol,
	input  logic [31:0] ip_source,
	input  logic [31:0] ip_destination,
	input  logic [15:0] udp_source_port,
	input  logic [15:0] udp_dest_port,
	input  logic [15:0] udp_length,
	input  logic [15:0] tftp_opcode,
	input  logic [15:0] tftp_block_or_code,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [15:0] data_count,
	output logic [15:0] ack_block,
	output logic [15:0] server_port_out,
	output logic        end_of_file,
	output logic [15:0] error_code,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import tftp_rx_pkg::*;

	// config
	logic [31:0] own_ip_q;
	logic [31:0] server_ip_q;
	logic [15:0] own_port_q;
	logic [3:0]  retry_limit_q;
	logic [15:0] block_size_q;

	// session state
	logic        sess_q;
	logic [15:0] blk_q;
	logic [15:0] port_q;
	logic        last_q;
	logic [3:0]  retry_q;

	// input register
	logic        valid_s1;
	logic [1:0]  req_s1;
	logic [15:0] flen_s1;
	logic [15:0] iplen_s1;
	logic [7:0]  proto_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;
	logic [15:0] sport_s1;
	logic [15:0] dport_s1;
	logic [15:0] ulen_s1;
	logic [15:0] opcode_s1;
	logic [15:0] blk_s1;

	// result register
	logic        out_valid_q;
	action_t     action_q;
	logic [15:0] count_q;
	logic [15:0] ack_q;
	logic [15:0] sport_out_q;
	logic        eof_q;
	logic [15:0] ecode_q;

	logic        adv;
	logic        in_take;

	logic        sess_d;
	logic [15:0] blk_d;
	logic [15:0] port_d;
	logic        last_d;
	logic [3:0]  retry_d;
	action_t     act_d;
	logic [15:0] count_d;
	logic [15:0] ecode_d;
	logic        ok;
	retry_t      rt;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q      <= OWN_IP_RST;
			server_ip_q   <= SERVER_IP_RST;
			own_port_q    <= OWN_PORT_RST;
			retry_limit_q <= RETRY_LIMIT_RST;
			block_size_q  <= BLOCK_SIZE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OWN_IP:      own_ip_q      <= cfg_data;
				CFG_SERVER_IP:   server_ip_q   <= cfg_data;
				CFG_OWN_PORT:    own_port_q    <= cfg_data[15:0];
				CFG_RETRY_LIMIT: retry_limit_q <= cfg_data[3:0];
				CFG_BLOCK_SIZE:  block_size_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1    <= req_type;
			flen_s1   <= frame_length;
			iplen_s1  <= ip_total_length;
			proto_s1  <= ip_protocol;
			src_s1    <= ip_source;
			dst_s1    <= ip_destination;
			sport_s1  <= udp_source_port;
			dport_s1  <= udp_dest_port;
			ulen_s1   <= udp_length;
			opcode_s1 <= tftp_opcode;
			blk_s1    <= tftp_block_or_code;
		end
	end

	always_comb begin
		sess_d  = sess_q;
		blk_d   = blk_q;
		port_d  = port_q;
		last_d  = last_q;
		retry_d = retry_q;
		act_d   = ACT_IGNORED;
		count_d = '0;
		ecode_d = '0;
		rt      = '0;

		ok = (flen_s1 >= HDR_MIN_LEN) && (iplen_s1 >= HDR_MIN_LEN) &&
			(proto_s1 == PROTO_UDP) && (ulen_s1 >= UDP_MIN_LEN) &&
			(dport_s1 == own_port_q) && (src_s1 == server_ip_q) &&
			((own_ip_q == 32'd0) || (dst_s1 == own_ip_q)) &&
			!(sess_q && (blk_q != 16'd0) && (sport_s1 != port_q));

		case (req_s1)
			REQ_START: begin
				sess_d  = 1'b0;
				blk_d   = '0;
				last_d  = 1'b0;
				retry_d = 4'd1;
				act_d   = ACT_REQUEST;
			end
			REQ_TIMEOUT: begin
				rt      = retry_step(last_q, retry_q, retry_limit_q, blk_q);
				retry_d = rt.count;
				act_d   = rt.action;
			end
			REQ_PACKET: begin
				if (ok && (opcode_s1 == OP_ERROR)) begin
					act_d   = ACT_SERVER_ERR;
					ecode_d = blk_s1;
				end else if (ok && (opcode_s1 == OP_DATA)) begin
					if (!sess_q) begin
						port_d = sport_s1;
						blk_d  = '0;
						last_d = 1'b0;
						sess_d = 1'b1;
					end
					if (blk_s1 != blk_d + 16'd1) begin
						rt      = retry_step(last_d, retry_q, retry_limit_q, blk_d);
						retry_d = rt.count;
						act_d   = rt.action;
					end else begin
						blk_d   = blk_s1;
						retry_d = '0;
						count_d = ulen_s1 - UDP_MIN_LEN;
						if (count_d < block_size_q) begin
							last_d = 1'b1;
						end
						act_d = ACT_DATA_ACK;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q  <= 1'b0;
			blk_q   <= '0;
			port_q  <= '0;
			last_q  <= 1'b0;
			retry_q <= '0;
		end else if (adv) begin
			sess_q  <= sess_d;
			blk_q   <= blk_d;
			port_q  <= port_d;
			last_q  <= last_d;
			retry_q <= retry_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_q    <= act_d;
			count_q     <= count_d;
			ack_q       <= blk_d;
			sport_out_q <= port_d;
			eof_q       <= last_d;
			ecode_q     <= ecode_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign action          = action_q;
	assign data_count      = count_q;
	assign ack_block       = ack_q;
	assign server_port_out = sport_out_q;
	assign end_of_file     = eof_q;
	assign error_code      = ecode_q;

	`TFTP_RX_ASSERT_NOW(a_stall_only_when_full, in_stall, valid_s1 && out_valid_q, "stall without full pipeline")
	`TFTP_RX_ASSERT_NEXT(a_ack_clears_retry, adv && (act_d == ACT_DATA_ACK), retry_q == 4'd0 && blk_q == $past(blk_s1), "accepted block did not update state")
	`TFTP_RX_ASSERT_NEXT(a_start_clears, adv && (req_s1 == REQ_START), !sess_q && blk_q == 16'd0 && !last_q && retry_q == 4'd1, "session start did not reset state")
	`TFTP_RX_ASSERT_NOW(a_out_tracks_state, out_valid_q, eof_q == last_q && ack_q == blk_q && sport_out_q == port_q, "result out of step with state")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import tftp_rx_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [15:0] OP_ACK = 16'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] frame_len;
		logic [15:0] ip_len;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] ulen;
		logic [15:0] opcode;
		logic [15:0] blk;
	} rx_req_t;

	typedef struct packed {
		action_t     act;
		logic [15:0] cnt;
		logic [15:0] ack;
		logic [15:0] srv_port;
		logic        eof;
		logic [15:0] ecode;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = '0;
	logic [15:0] frame_length = '0;
	logic [15:0] ip_total_length = '0;
	logic [7:0]  ip_protocol = '0;
	logic [31:0] ip_source = '0;
	logic [31:0] ip_destination = '0;
	logic [15:0] udp_source_port = '0;
	logic [15:0] udp_dest_port = '0;
	logic [15:0] udp_length = '0;
	logic [15:0] tftp_opcode = '0;
	logic [15:0] tftp_block_or_code = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  action;
	logic [15:0] data_count;
	logic [15:0] ack_block;
	logic [15:0] server_port_out;
	logic        end_of_file;
	logic [15:0] error_code;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	tftp_client_receive u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.req_type           (req_type),
		.frame_length       (frame_length),
		.ip_total_length    (ip_total_length),
		.ip_protocol        (ip_protocol),
		.ip_source          (ip_source),
		.ip_destination     (ip_destination),
		.udp_source_port    (udp_source_port),
		.udp_dest_port      (udp_dest_port),
		.udp_length         (udp_length),
		.tftp_opcode        (tftp_opcode),
		.tftp_block_or_code (tftp_block_or_code),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.action             (action),
		.data_count         (data_count),
		.ack_block          (ack_block),
		.server_port_out    (server_port_out),
		.end_of_file        (end_of_file),
		.error_code         (error_code),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	// register copies
	logic [31:0] cfg_own_ip = OWN_IP_RST;
	logic [31:0] cfg_srv_ip = SERVER_IP_RST;
	logic [15:0] cfg_own_port = OWN_PORT_RST;
	logic [3:0]  cfg_retry_lim = RETRY_LIMIT_RST;
	logic [15:0] cfg_blk_size = BLOCK_SIZE_RST;

	// session state
	logic        sess_open = 1'b0;
	logic [15:0] blk_cnt = '0;
	logic [15:0] srv_port = '0;
	logic        got_last = 1'b0;
	logic [3:0]  retries = '0;

	// generator view of the transfer
	logic [15:0] gen_blk = '0;
	logic [15:0] gen_port = '0;
	logic        gen_ended = 1'b0;

	rx_req_t rx_backlog[$];
	reply_t  replies_due[$];
	rx_req_t offered;
	int      err_cnt = 0;
	int      cyc = 0;
	int      seen_cnt = 0;
	int      hold_left = 0;
	bit      held = 1'b0;

	wire calm = (cyc % 6000) < 1500;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic action_t retry_action();
		if (got_last)
			return ACT_FINISHED;
		if (retries >= cfg_retry_lim)
			return ACT_GIVE_UP;
		retries = retries + 4'd1;
		return (blk_cnt == 16'd0) ? ACT_RESEND_REQ : ACT_RESEND_ACK;
	endfunction

	function automatic void session_step(input rx_req_t r);
		reply_t e;
		logic   ok;
		e = '0;
		e.act = ACT_IGNORED;
		case (r.kind)
			REQ_START: begin
				sess_open = 1'b0;
				blk_cnt = '0;
				got_last = 1'b0;
				retries = 4'd1;
				e.act = ACT_REQUEST;
			end
			REQ_TIMEOUT: e.act = retry_action();
			REQ_PACKET: begin
				ok = r.frame_len >= HDR_MIN_LEN && r.ip_len >= HDR_MIN_LEN &&
					r.proto == PROTO_UDP && r.ulen >= UDP_MIN_LEN &&
					r.dport == cfg_own_port && r.src == cfg_srv_ip;
				if (cfg_own_ip != 32'd0 && r.dst != cfg_own_ip)
					ok = 1'b0;
				if (sess_open && blk_cnt != 16'd0 && r.sport != srv_port)
					ok = 1'b0;
				if (ok && r.opcode == OP_ERROR) begin
					e.act = ACT_SERVER_ERR;
					e.ecode = r.blk;
				end else if (ok && r.opcode == OP_DATA) begin
					if (!sess_open) begin
						srv_port = r.sport;
						blk_cnt = '0;
						got_last = 1'b0;
						sess_open = 1'b1;
					end
					if (r.blk != blk_cnt + 16'd1) begin
						e.act = retry_action();
					end else begin
						blk_cnt = r.blk;
						retries = '0;
						e.cnt = r.ulen - UDP_MIN_LEN;
						if (e.cnt < cfg_blk_size)
							got_last = 1'b1;
						e.act = ACT_DATA_ACK;
					end
				end
			end
			default: ;
		endcase
		e.ack = blk_cnt;
		e.srv_port = srv_port;
		e.eof = got_last;
		replies_due.push_back(e);
	endfunction

	function automatic rx_req_t any_req(input logic [1:0] kind);
		rx_req_t r;
		r.kind = kind;
		r.frame_len = 16'($urandom);
		r.ip_len = 16'($urandom);
		r.proto = 8'($urandom);
		r.src = $urandom;
		r.dst = $urandom;
		r.sport = 16'($urandom);
		r.dport = 16'($urandom);
		r.ulen = 16'($urandom);
		r.opcode = 16'($urandom);
		r.blk = 16'($urandom);
		return r;
	endfunction

	function automatic rx_req_t good_packet(input logic [15:0] op, input logic [15:0] bnum,
		input logic [15:0] ulen);
		rx_req_t r;
		r.kind = REQ_PACKET;
		r.frame_len = 16'($urandom_range(65535, 32));
		r.ip_len = 16'($urandom_range(65535, 32));
		r.proto = PROTO_UDP;
		r.src = cfg_srv_ip;
		r.dst = (cfg_own_ip != 32'd0) ? cfg_own_ip : $urandom;
		r.sport = gen_port;
		r.dport = cfg_own_port;
		r.ulen = ulen;
		r.opcode = op;
		r.blk = bnum;
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			err_cnt++;
		end
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_OWN_IP: cfg_own_ip = val;
			CFG_SERVER_IP: cfg_srv_ip = val;
			CFG_OWN_PORT: cfg_own_port = val[15:0];
			CFG_RETRY_LIMIT: cfg_retry_lim = val[3:0];
			CFG_BLOCK_SIZE: cfg_blk_size = val[15:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] own, input logic [31:0] srv,
		input logic [15:0] uport, input logic [3:0] lim, input logic [15:0] bsize);
		write_reg(CFG_OWN_IP, own);
		write_reg(CFG_SERVER_IP, srv);
		write_reg(CFG_OWN_PORT, {16'd0, uport});
		write_reg(CFG_RETRY_LIMIT, {28'd0, lim});
		write_reg(CFG_BLOCK_SIZE, {16'd0, bsize});
	endtask

	task automatic drain();
		do @(negedge clk);
		while (rx_backlog.size() != 0 || in_valid || replies_due.size() != 0);
	endtask

	// mostly in-order transfers with retransmits, timeouts, errors and junk mixed in
	task automatic random_phase(input int n);
		rx_req_t     r;
		int          pick;
		int          which;
		logic [15:0] top_cnt;
		top_cnt = (cfg_blk_size > 16'd65523) ? 16'd65523 : cfg_blk_size;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 6 || (gen_ended && pick < 25)) begin
				r = any_req(REQ_START);
				gen_blk = '0;
				gen_ended = 1'b0;
				gen_port = 16'($urandom);
			end else if (pick < 60) begin
				gen_blk = gen_blk + 16'd1;
				if ($urandom_range(9) == 0) begin
					r = good_packet(OP_DATA, gen_blk,
						16'($urandom_range(top_cnt - 16'd1, 0)) + UDP_MIN_LEN);
					gen_ended = 1'b1;
				end else begin
					r = good_packet(OP_DATA, gen_blk, top_cnt + UDP_MIN_LEN);
				end
			end else if (pick < 66) begin
				r = good_packet(OP_DATA, $urandom_range(1) ? gen_blk : 16'($urandom),
					top_cnt + UDP_MIN_LEN);
			end else if (pick < 74) begin
				r = any_req(REQ_TIMEOUT);
			end else if (pick < 78) begin
				r = good_packet(OP_ERROR, 16'($urandom), 16'($urandom_range(65535, 12)));
				if ($urandom_range(3) == 0)
					r.opcode = 16'($urandom);
			end else if (pick < 90) begin
				r = good_packet(OP_DATA, gen_blk + 16'd1, top_cnt + UDP_MIN_LEN);
				which = $urandom_range(7);
				if (which == 6 && cfg_own_ip == 32'd0)
					which = 5;
				if (which == 7 && gen_blk == 16'd0)
					which = 4;
				case (which)
					0: r.frame_len = 16'($urandom_range(31));
					1: r.ip_len = 16'($urandom_range(31));
					2: r.proto = r.proto ^ 8'($urandom_range(255, 1));
					3: r.ulen = 16'($urandom_range(11));
					4: r.dport = r.dport ^ 16'($urandom_range(65535, 1));
					5: r.src = r.src ^ ($urandom | 32'd1);
					6: r.dst = r.dst ^ ($urandom | 32'd1);
					default: r.sport = r.sport ^ 16'($urandom_range(65535, 1));
				endcase
			end else begin
				r = any_req(2'($urandom_range(3)));
			end
			rx_backlog.push_back(r);
		end
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				session_step(offered);
			if (!in_valid || !in_stall) begin
				if (rx_backlog.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
					offered = rx_backlog.pop_front();
					in_valid <= 1'b1;
					req_type <= offered.kind;
					frame_length <= offered.frame_len;
					ip_total_length <= offered.ip_len;
					ip_protocol <= offered.proto;
					ip_source <= offered.src;
					ip_destination <= offered.dst;
					udp_source_port <= offered.sport;
					udp_dest_port <= offered.dport;
					udp_length <= offered.ulen;
					tftp_opcode <= offered.opcode;
					tftp_block_or_code <= offered.blk;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : rx_side
		reply_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual action %0d",
						$time, action);
					err_cnt++;
				end else begin
					want = replies_due.pop_front();
					check_field("action", want.act, action);
					check_field("data_count", want.cnt, data_count);
					check_field("ack_block", want.ack, ack_block);
					check_field("server_port_out", want.srv_port, server_port_out);
					check_field("end_of_file", want.eof, end_of_file);
					check_field("error_code", want.ecode, error_code);
				end
				seen_cnt++;
			end
			// one long hold-off so the input side backs up
			if (hold_left > 0) begin
				hold_left--;
			end else if (!held && seen_cnt == 600) begin
				held = 1'b1;
				hold_left = 200;
			end
			out_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 33);
		end
	end

	initial begin
		rx_req_t     r;
		logic [31:0] own;
		logic [31:0] srv;
		logic [15:0] uport;
		logic [3:0]  lim;
		logic [15:0] bsize;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: drop rules, error, first block, port latch, retries, end of file
		set_config(32'h0A00_0002, 32'h0A00_0001, 16'd50000, 4'd2, 16'd512);
		gen_port = 16'h1234;
		rx_backlog.push_back(any_req(REQ_TIMEOUT));
		rx_backlog.push_back(any_req(REQ_UNUSED));
		rx_backlog.push_back(any_req(REQ_START));
		r = good_packet(OP_DATA, 16'd1, 16'd524);
		r.frame_len = HDR_MIN_LEN - 16'd1;
		rx_backlog.push_back(r);
		r = good_packet(OP_DATA, 16'd1, 16'd524);
		r.ip_len = HDR_MIN_LEN - 16'd1;
		rx_backlog.push_back(r);
		r = good_packet(OP_DATA, 16'd1, 16'd524);
		r.proto = PROTO_UDP - 8'd1;
		rx_backlog.push_back(r);
		r = good_packet(OP_DATA, 16'd1, UDP_MIN_LEN - 16'd1);
		rx_backlog.push_back(r);
		r = good_packet(OP_DATA, 16'd1, 16'd524);
		r.dport = r.dport ^ 16'd1;
		rx_backlog.push_back(r);
		r = good_packet(OP_DATA, 16'd1, 16'd524);
		r.src = r.src ^ 32'd1;
		rx_backlog.push_back(r);
		r = good_packet(OP_DATA, 16'd1, 16'd524);
		r.dst = r.dst ^ 32'd1;
		rx_backlog.push_back(r);
		rx_backlog.push_back(good_packet(OP_ACK, 16'd1, 16'd524));
		rx_backlog.push_back(good_packet(OP_ERROR, 16'hFFFF, 16'd20));
		rx_backlog.push_back(good_packet(OP_DATA, 16'd7, 16'd524));
		r = good_packet(OP_DATA, 16'd1, 16'd524);
		r.sport = 16'hBEEF;
		r.frame_len = 16'hFFFF;
		r.ip_len = 16'hFFFF;
		rx_backlog.push_back(r);
		r = good_packet(OP_DATA, 16'd2, 16'd524);
		r.sport = 16'hBEEF;
		rx_backlog.push_back(r);
		rx_backlog.push_back(good_packet(OP_DATA, 16'd1, 16'd524));
		rx_backlog.push_back(any_req(REQ_TIMEOUT));
		rx_backlog.push_back(any_req(REQ_TIMEOUT));
		r = good_packet(OP_DATA, 16'd2, UDP_MIN_LEN);
		r.frame_len = HDR_MIN_LEN;
		r.ip_len = HDR_MIN_LEN;
		rx_backlog.push_back(r);
		rx_backlog.push_back(any_req(REQ_TIMEOUT));
		rx_backlog.push_back(good_packet(OP_DATA, 16'd9, 16'd524));
		rx_backlog.push_back(any_req(REQ_START));
		gen_port = 16'hFFFF;
		r = good_packet(OP_DATA, 16'd1, 16'hFFFF);
		r.frame_len = 16'hFFFF;
		r.ip_len = 16'hFFFF;
		rx_backlog.push_back(r);
		r = '0;
		r.kind = REQ_PACKET;
		rx_backlog.push_back(r);
		drain();

		for (int p = 0; p < 8; p++) begin
			own = (p % 3 == 0) ? 32'd0 : (p % 3 == 1) ? 32'hFFFF_FFFF : $urandom;
			srv = (p % 4 == 0) ? 32'd0 : (p % 4 == 1) ? 32'hFFFF_FFFF : $urandom;
			uport = (p % 3 == 0) ? 16'hFFFF : (p % 3 == 1) ? 16'd0 : 16'($urandom);
			lim = (p % 3 == 0) ? 4'd1 : (p % 3 == 1) ? 4'd15 : 4'($urandom_range(15, 1));
			case (p % 4)
				0: bsize = 16'd1;
				1: bsize = 16'hFFFF;
				2: bsize = 16'd512;
				default: bsize = 16'($urandom_range(65535, 1));
			endcase
			set_config(own, srv, uport, lim, bsize);
			rx_backlog.push_back(any_req(REQ_START));
			gen_blk = '0;
			gen_ended = 1'b0;
			gen_port = 16'($urandom);
			random_phase(200);
			drain();
		end

		// long in-order run, then a timeout and packets from a foreign port
		set_config($urandom, $urandom, 16'($urandom), 4'd15, 16'd1);
		gen_port = 16'($urandom);
		rx_backlog.push_back(any_req(REQ_START));
		for (int b = 1; b <= 120; b++)
			rx_backlog.push_back(good_packet(OP_DATA, 16'(b),
				16'($urandom_range(65535, 13))));
		rx_backlog.push_back(any_req(REQ_TIMEOUT));
		r = good_packet(OP_DATA, 16'd5, 16'd100);
		r.sport = ~gen_port;
		rx_backlog.push_back(r);
		r = good_packet(OP_DATA, 16'd1, UDP_MIN_LEN);
		r.sport = ~gen_port;
		rx_backlog.push_back(r);
		rx_backlog.push_back(any_req(REQ_TIMEOUT));
		drain();

		repeat (4) @(posedge clk);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
